### sv/ackd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ackd_pkg
// Shared types, constants and result helpers for the acknowledge deframer.
// ----------------------------------------------------------------------------
package ackd_pkg;

	// payload buffer depth and derived widths
	localparam int MAX_PAYLOAD = 32;
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int PLEN_W      = $clog2(MAX_PAYLOAD + 1);
	localparam int LEN_W       = $clog2(MAX_PAYLOAD + 4);
	localparam int BC_W        = $clog2(MAX_PAYLOAD + 2);

	// fixed field width and result queue depth
	localparam int COUNT_W = 6;
	localparam int QDEPTH  = 2;

	// framing constants
	localparam logic [7:0] SYNC_FIRST  = 8'hEF;
	localparam logic [7:0] SYNC_SECOND = 8'h01;
	localparam logic [7:0] ACK_ID      = 8'h07;

	// input operation codes
	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RX_ERR  = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	// parser phases
	typedef enum logic [9:0] {
		PH_IDLE    = 10'b00_0000_0001,
		PH_HUNT    = 10'b00_0000_0010,
		PH_SYNC2   = 10'b00_0000_0100,
		PH_ADDR    = 10'b00_0000_1000,
		PH_ID      = 10'b00_0001_0000,
		PH_LEN_HI  = 10'b00_0010_0000,
		PH_LEN_LO  = 10'b00_0100_0000,
		PH_CONTENT = 10'b00_1000_0000,
		PH_SUM_HI  = 10'b01_0000_0000,
		PH_SUM_LO  = 10'b10_0000_0000
	} phase_t;

	// one result transaction
	typedef struct packed {
		logic               is_status;
		logic [7:0]         data_byte;
		logic [1:0]         status;
		logic [7:0]         confirm_code;
		logic [COUNT_W-1:0] payload_count;
		logic               last;
	} result_t;

	// status result
	function automatic result_t mk_status(logic [1:0] st, logic [7:0] conf,
		logic [COUNT_W-1:0] cnt);
		result_t r;
		r.is_status     = 1'b1;
		r.data_byte     = 8'd0;
		r.status        = st;
		r.confirm_code  = conf;
		r.payload_count = cnt;
		r.last          = 1'b1;
		return r;
	endfunction

	// payload byte result
	function automatic result_t mk_data(logic [7:0] b);
		result_t r;
		r.is_status     = 1'b0;
		r.data_byte     = b;
		r.status        = ST_OK;
		r.confirm_code  = 8'd0;
		r.payload_count = '0;
		r.last          = 1'b0;
		return r;
	endfunction

endpackage

### sv/ack_packet_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_packet_deframer_top
// Acknowledge packet deframer: sync hunt, header parse, checksum, payload out.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_ready  op, rx_byte, wait_ms, capacity
//  out      source     out_valid/out_ready  is_status, data_byte, status,
//                                           confirm_code, payload_count, last
//
//  one input transaction per cycle while no payload readout runs and the
//  two-entry result queue has room; a result may wait while input flows.
//  a packet's payload bytes are read one at a time, a read issuing only while
//  the queue has a slot free of the read in flight; input pauses until the
//  readout ends with its status result, and longer if the output stalls.
//  reset clears all control state; the payload memory needs no clearing pass.
// ----------------------------------------------------------------------------
module ack_packet_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] wait_ms,
	input  logic [5:0]  capacity,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_status,
	output logic [7:0]  data_byte,
	output logic [1:0]  status,
	output logic [7:0]  confirm_code,
	output logic [5:0]  payload_count,
	output logic        last
);

	localparam int CMP_W = ackd_pkg::LEN_W + 1;
	localparam int CAP_W = ackd_pkg::COUNT_W + 1;

	// parser state
	ackd_pkg::phase_t                phase_q, phase_d;
	logic [2:0]                      hidx_q, hidx_d;
	logic [7:0]                      pid_q, pid_d;
	logic [7:0]                      len_hi_q, len_hi_d;
	logic [ackd_pkg::LEN_W-1:0]      len_q, len_d;
	logic [ackd_pkg::BC_W-1:0]       bc_q, bc_d;
	logic [15:0]                     sum_q, sum_d;
	logic [7:0]                      rsum_hi_q, rsum_hi_d;
	logic [7:0]                      conf_q, conf_d;
	logic [15:0]                     elapsed_q, elapsed_d;
	logic [15:0]                     limit_q, limit_d;
	logic [ackd_pkg::COUNT_W-1:0]    cap_q, cap_d;

	// readout state
	logic                            burst_q;
	logic [ackd_pkg::PLEN_W-1:0]     rd_ptr_q;
	logic [ackd_pkg::PLEN_W-1:0]     plen_q;
	logic                            inflight_s1;
	logic [7:0]                      rd_data_s1;

	// payload memory
	logic [7:0]                      mem [ackd_pkg::MAX_PAYLOAD];
	logic                            mem_we;
	logic [ackd_pkg::ADDR_W-1:0]     mem_wa;

	// per-cycle control
	logic                            in_fire;
	logic                            in_push;
	ackd_pkg::result_t               in_res;
	logic                            burst_go;
	logic [ackd_pkg::PLEN_W-1:0]     plen_calc;
	logic [15:0]                     len_full;
	logic [15:0]                     sum_add;
	logic [15:0]                     elapsed_inc;
	logic [15:0]                     rsum_full;
	logic [ackd_pkg::BC_W-1:0]       bc_inc;
	logic [2:0]                      hidx_inc;
	logic                            rd_en;
	logic                            st_push;
	logic [2:0]                      occ;

	// queue interface
	logic                            q_push;
	logic                            q_pop;
	ackd_pkg::result_t               q_data;
	ackd_pkg::result_t               q_head;
	logic [1:0]                      q_count;

	assign in_ready = !burst_q && (q_count < 2'(ackd_pkg::QDEPTH));
	assign in_fire  = in_valid && in_ready;

	assign len_full    = {len_hi_q, rx_byte};
	assign sum_add     = sum_q + 16'(rx_byte);
	assign elapsed_inc = elapsed_q + 16'd1;
	assign rsum_full   = {rsum_hi_q, rx_byte};
	assign bc_inc      = bc_q + ackd_pkg::BC_W'(1);
	assign hidx_inc    = hidx_q + 3'd1;
	assign plen_calc   = ackd_pkg::PLEN_W'(len_q - ackd_pkg::LEN_W'(3));

	// parser next state
	always_comb begin
		phase_d   = phase_q;
		hidx_d    = hidx_q;
		pid_d     = pid_q;
		len_hi_d  = len_hi_q;
		len_d     = len_q;
		bc_d      = bc_q;
		sum_d     = sum_q;
		rsum_hi_d = rsum_hi_q;
		conf_d    = conf_q;
		elapsed_d = elapsed_q;
		limit_d   = limit_q;
		cap_d     = cap_q;
		in_push   = 1'b0;
		in_res    = ackd_pkg::mk_status(ackd_pkg::ST_RX_ERR, 8'd0, '0);
		mem_we    = 1'b0;
		mem_wa    = ackd_pkg::ADDR_W'(bc_q - ackd_pkg::BC_W'(1));
		burst_go  = 1'b0;
		if (in_fire) begin
			if (op == ackd_pkg::OP_START) begin
				limit_d   = wait_ms;
				cap_d     = capacity;
				elapsed_d = 16'd0;
				hidx_d    = 3'd0;
				bc_d      = '0;
				sum_d     = 16'd0;
				phase_d   = ackd_pkg::PH_HUNT;
				if (wait_ms == 16'd0) begin
					in_push = 1'b1;
					in_res  = ackd_pkg::mk_status(ackd_pkg::ST_TIMEOUT, 8'd0, '0);
					phase_d = ackd_pkg::PH_IDLE;
				end
			end else if (phase_q != ackd_pkg::PH_IDLE) begin
				if (op == ackd_pkg::OP_TICK) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= limit_q) begin
						in_push = 1'b1;
						in_res  = ackd_pkg::mk_status(ackd_pkg::ST_TIMEOUT, 8'd0, '0);
						phase_d = ackd_pkg::PH_IDLE;
					end
				end else if (op == ackd_pkg::OP_BYTE) begin
					unique case (phase_q)
						ackd_pkg::PH_HUNT: begin
							if (rx_byte == ackd_pkg::SYNC_FIRST) begin
								phase_d = ackd_pkg::PH_SYNC2;
							end
						end
						ackd_pkg::PH_SYNC2: begin
							if (rx_byte == ackd_pkg::SYNC_SECOND) begin
								phase_d = ackd_pkg::PH_ADDR;
								hidx_d  = 3'd0;
							end else if (rx_byte != ackd_pkg::SYNC_FIRST) begin
								phase_d = ackd_pkg::PH_HUNT;
							end
						end
						ackd_pkg::PH_ADDR: begin
							hidx_d = hidx_inc;
							if (hidx_inc >= 3'd4) begin
								phase_d = ackd_pkg::PH_ID;
							end
						end
						ackd_pkg::PH_ID: begin
							pid_d   = rx_byte;
							sum_d   = 16'(rx_byte);
							phase_d = ackd_pkg::PH_LEN_HI;
						end
						ackd_pkg::PH_LEN_HI: begin
							len_hi_d = rx_byte;
							sum_d    = sum_add;
							phase_d  = ackd_pkg::PH_LEN_LO;
						end
						ackd_pkg::PH_LEN_LO: begin
							sum_d = sum_add;
							len_d = ackd_pkg::LEN_W'(len_full);
							if (len_full < 16'd3 ||
								len_full > 16'(ackd_pkg::MAX_PAYLOAD + 3)) begin
								in_push = 1'b1;
								phase_d = ackd_pkg::PH_IDLE;
							end else begin
								bc_d    = '0;
								phase_d = ackd_pkg::PH_CONTENT;
							end
						end
						ackd_pkg::PH_CONTENT: begin
							// first content byte is the confirmation code
							if (bc_q == '0) begin
								conf_d = rx_byte;
							end else begin
								mem_we = 1'b1;
							end
							sum_d = sum_add;
							bc_d  = bc_inc;
							if (CMP_W'(bc_inc) + CMP_W'(2) >= CMP_W'(len_q)) begin
								phase_d = ackd_pkg::PH_SUM_HI;
							end
						end
						ackd_pkg::PH_SUM_HI: begin
							rsum_hi_d = rx_byte;
							phase_d   = ackd_pkg::PH_SUM_LO;
						end
						ackd_pkg::PH_SUM_LO: begin
							phase_d = ackd_pkg::PH_IDLE;
							if (pid_q != ackd_pkg::ACK_ID || rsum_full != sum_q) begin
								in_push = 1'b1;
							end else if (CAP_W'(cap_q) >= CAP_W'(plen_calc) &&
								plen_calc != '0) begin
								burst_go = 1'b1;
							end else begin
								in_push = 1'b1;
								in_res  = ackd_pkg::mk_status(ackd_pkg::ST_OK, conf_q, '0);
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ackd_pkg::PH_IDLE;
			hidx_q    <= 3'd0;
			pid_q     <= 8'd0;
			len_hi_q  <= 8'd0;
			len_q     <= '0;
			bc_q      <= '0;
			sum_q     <= 16'd0;
			rsum_hi_q <= 8'd0;
			conf_q    <= 8'd0;
			elapsed_q <= 16'd0;
			limit_q   <= 16'd0;
			cap_q     <= '0;
		end else begin
			phase_q   <= phase_d;
			hidx_q    <= hidx_d;
			pid_q     <= pid_d;
			len_hi_q  <= len_hi_d;
			len_q     <= len_d;
			bc_q      <= bc_d;
			sum_q     <= sum_d;
			rsum_hi_q <= rsum_hi_d;
			conf_q    <= conf_d;
			elapsed_q <= elapsed_d;
			limit_q   <= limit_d;
			cap_q     <= cap_d;
		end
	end

	// readout control: one read per cycle while the queue has a slot not yet reserved by the read in flight
	assign occ     = {1'b0, q_count} + {2'b00, inflight_s1};
	assign rd_en   = burst_q && (rd_ptr_q != plen_q) && (occ < 3'(ackd_pkg::QDEPTH));
	assign st_push = burst_q && (rd_ptr_q == plen_q) && !inflight_s1 &&
		(q_count < 2'(ackd_pkg::QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q     <= 1'b0;
			rd_ptr_q    <= '0;
			plen_q      <= '0;
			inflight_s1 <= 1'b0;
		end else begin
			inflight_s1 <= rd_en;
			if (burst_go) begin
				burst_q  <= 1'b1;
				rd_ptr_q <= '0;
				plen_q   <= plen_calc;
			end else if (burst_q) begin
				if (rd_en) begin
					rd_ptr_q <= rd_ptr_q + ackd_pkg::PLEN_W'(1);
				end
				if (st_push) begin
					burst_q <= 1'b0;
				end
			end
		end
	end

	// payload memory, last write lands before the checksum bytes arrive and so before readout
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= rx_byte;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_ptr_q[ackd_pkg::ADDR_W-1:0]];
		end
	end

	// result selection into the queue
	always_comb begin
		q_push = in_push || inflight_s1 || st_push;
		if (inflight_s1) begin
			q_data = ackd_pkg::mk_data(rd_data_s1);
		end else if (st_push) begin
			q_data = ackd_pkg::mk_status(ackd_pkg::ST_OK, conf_q,
				ackd_pkg::COUNT_W'(plen_q));
		end else begin
			q_data = in_res;
		end
	end

	assign q_pop = out_valid && out_ready;

	ackd_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.count     (q_count)
	);

	// output ports from the queue head
	assign out_valid     = (q_count != 2'd0);
	assign is_status     = q_head.is_status;
	assign data_byte     = q_head.data_byte;
	assign status        = q_head.status;
	assign confirm_code  = q_head.confirm_code;
	assign payload_count = q_head.payload_count;
	assign last          = q_head.last;

	a_no_write_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !burst_q)
		else $error("payload write during readout");

	a_slot_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= 3'(ackd_pkg::QDEPTH))
		else $error("queue slots overcommitted");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q |-> (rd_ptr_q <= plen_q))
		else $error("read pointer past payload length");

	a_burst_idles: assert property (@(posedge clk) disable iff (!arst_n)
		burst_go |=> (burst_q && phase_q == ackd_pkg::PH_IDLE && !in_ready))
		else $error("readout start did not idle the parser");

endmodule

### sv/ackd_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ackd_result_queue
// Two-entry result queue between the deframer and the output channel.
// ----------------------------------------------------------------------------
module ackd_result_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ackd_pkg::result_t push_data,
	input  logic             pop,
	output ackd_pkg::result_t head,
	output logic [1:0]       count
);

	ackd_pkg::result_t e0_q, e1_q;
	logic [1:0]        count_q;

	assign head  = e0_q;
	assign count = count_q;

	// occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	// entry storage, head in e0
	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && count_q == 2'd1) begin
				e0_q <= push_data;
			end else begin
				e0_q <= e1_q;
				if (push) begin
					e1_q <= push_data;
				end
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				e0_q <= push_data;
			end else begin
				e1_q <= push_data;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && count_q == 2'(ackd_pkg::QDEPTH)) |-> pop)
		else $error("result queue overflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(ackd_pkg::QDEPTH))
		else $error("result queue count out of range");

	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != 2'd0 && !pop) |=> $stable(e0_q))
		else $error("queue head changed without pop");

endmodule
